[sv/stk_pkg.sv]
// Shared types and command codes for the sorted top-k score buffer.
`default_nettype none
package stk_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_READ   = 3'd3,
        CMD_LOOKUP = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FETCH,
        ST_FINISH,
        ST_PRES,
        ST_OUT
    } state_t;

    localparam int unsigned IN_BITS  = 3 + 32 + 32 + 64 + 4;
    localparam int unsigned IN_BYTES = (IN_BITS + 7) / 8;
    localparam int unsigned OUT_BITS = 3 + 32 + 32 + 64 + 32;
    localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

endpackage
`default_nettype wire

[sv/sorted_top_k_score_buffer_top.sv]
// Top level of the sorted top-k score buffer: control sequencer and entry memories.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | tdata = cmd, key_id, new_score, new_payload, rank
//  m_axis   | out       | tdata = status, found, present, out_id, out_score,
//           |           |         out_payload, min_score
//
// An insert or delete first searches the ranks in order, each rank step being a rank read,
// a slot read and a compare; when the search stops on a rank, the rank list is shifted
// with a read and a write per moved rank. Every command ends with a presence scan over
// the slots and a read of the last rank's score. After reset the rank and slot memories
// are initialized before the first beat is taken. The result sits in an output register;
// a stalled m_axis holds the sequencer in its output state, and s_axis is ready only when
// idle.
`default_nettype none
module sorted_top_k_score_buffer_top #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire  logic                                clk,
    input  wire  logic                                rst_n,
    input  wire  logic                                s_axis_tvalid,
    output logic                                      s_axis_tready,
    // cmd[2:0], key_id[34:3], new_score[66:35], new_payload[130:67], rank[134:131]
    input  wire  logic [stk_pkg::IN_BYTES*8-1:0]      s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire  logic                                m_axis_tready,
    // status[0], found[1], present[2], out_id[34:3], out_score[66:35],
    // out_payload[130:67], min_score[162:131]
    output logic [stk_pkg::OUT_BYTES*8-1:0]           m_axis_tdata
);
    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = AW + 1;
    localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);
    localparam logic [CW-1:0] CNT  = CW'(ENTRIES);

    // Slot memory holds id, score and payload; rank memory holds slot numbers.
    logic [127:0]  slot_mem [ENTRIES];
    logic [AW-1:0] rank_mem [ENTRIES];

    logic          init_reg;
    logic [CW-1:0] init_cnt_reg;

    stk_pkg::state_t state_reg, state_next;
    logic [2:0]      cmd_reg;
    logic [31:0]     key_reg, score_reg;
    logic [63:0]     pay_reg;
    logic [3:0]      rnk_reg;
    logic [CW-1:0]   idx_reg, idx_next;     // address being presented
    logic [CW-1:0]   hit_reg, hit_next;     // rank where the search stopped
    logic            hitv_reg, hitv_next;
    logic            pv_reg;                // a read was issued last cycle
    logic [CW-1:0]   pidx_reg;              // which index that read was
    logic [AW-1:0]   carry_reg, carry_next; // slot number of the rank under compare
    logic [AW-1:0]   victim_reg, victim_next;
    logic            status_reg, status_next, found_reg, found_next;
    logic            present_reg, present_next;
    logic [127:0]    ent_reg, ent_next;
    logic [31:0]     min_reg, min_next;
    logic            phase_reg, phase_next; // second pass of a scan

    logic [127:0]  slot_rd_reg;
    logic [AW-1:0] rank_rd_reg;
    logic [AW-1:0] slot_raddr, slot_waddr, rank_raddr, rank_waddr;
    logic [127:0]  slot_wdata;
    logic [AW-1:0] rank_wdata;
    logic          slot_we, rank_we, rd_en;

    logic [AW-1:0] idx_a;
    assign idx_a = idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        slot_rd_reg <= slot_mem[slot_raddr];
        rank_rd_reg <= rank_mem[rank_raddr];
    end

    assign s_axis_tready = init_reg && (state_reg == stk_pkg::ST_IDLE);
    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    // Slot number of the rank read that came back this cycle.
    logic [AW-1:0] rslot;
    assign rslot = rank_rd_reg;

    // Pass structure:
    //  SCAN: walk ranks, read rank_mem (idx) in phase 0, then the slot it names in phase 1.
    //  Each rank step is a rank read, a slot read and a compare.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        hitv_next    = hitv_reg;
        carry_next   = carry_reg;
        victim_next  = victim_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        present_next = present_reg;
        ent_next     = ent_reg;
        min_next     = min_reg;
        phase_next   = phase_reg;
        slot_raddr   = idx_a;
        rank_raddr   = idx_a;
        slot_we      = !init_reg;
        slot_waddr   = init_cnt_reg[AW-1:0];
        slot_wdata   = '0;
        rank_we      = !init_reg;
        rank_waddr   = init_cnt_reg[AW-1:0];
        rank_wdata   = init_cnt_reg[AW-1:0];
        rd_en        = 1'b0;
        case (state_reg)
            stk_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next     = '0;
                    hitv_next    = 1'b0;
                    status_next  = 1'b0;
                    found_next   = 1'b0;
                    present_next = 1'b0;
                    ent_next     = '0;
                    phase_next   = 1'b0;
                    state_next   = stk_pkg::ST_SCAN;
                end
            end
            stk_pkg::ST_SCAN:
            begin
                // phase 0: rank read at idx issued; phase 1: slot read issued.
                if (cmd_reg == stk_pkg::CMD_CLEAR)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = idx_a;
                    slot_wdata = '0;
                    if (idx_reg == LAST)
                    begin
                        idx_next   = '0;
                        state_next = stk_pkg::ST_PRES;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (cmd_reg == stk_pkg::CMD_LOOKUP)
                begin
                    // slot order: read slot idx, examine it in the next cycle
                    rd_en = 1'b1;
                    if (pv_reg && !found_reg && slot_rd_reg[31:0] == key_reg)
                    begin
                        found_next = 1'b1;
                        ent_next   = slot_rd_reg;
                    end
                    if (idx_reg == CNT)
                    begin
                        idx_next   = '0;
                        rd_en      = 1'b0;
                        state_next = stk_pkg::ST_PRES;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (cmd_reg == stk_pkg::CMD_READ)
                begin
                    if (!phase_reg)
                    begin
                        rank_raddr = AW'(rnk_reg);
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        slot_raddr = rslot;
                        phase_next = 1'b0;
                        state_next = stk_pkg::ST_FETCH;
                    end
                end
                else if (cmd_reg == stk_pkg::CMD_INSERT || cmd_reg == stk_pkg::CMD_DELETE)
                begin
                    // per rank: rank read, slot read, compare
                    if (!phase_reg)
                    begin
                        if (idx_reg == CNT || hitv_reg)
                        begin
                            state_next = stk_pkg::ST_SHIFT;
                            phase_next = 1'b0;
                            if (!hitv_reg)
                            begin
                                status_next = (cmd_reg == stk_pkg::CMD_INSERT);
                                state_next  = stk_pkg::ST_PRES;
                                idx_next    = '0;
                            end
                            else if (cmd_reg == stk_pkg::CMD_INSERT)
                            begin
                                // fetch victim from last rank first
                                idx_next = LAST;
                            end
                            else
                            begin
                                idx_next = hit_reg;
                            end
                        end
                        else
                        begin
                            phase_next = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        state_next = stk_pkg::ST_FETCH;
                        slot_raddr = rslot;
                        carry_next = rslot;
                    end
                end
                else
                begin
                    idx_next   = '0;
                    state_next = stk_pkg::ST_PRES;
                end
            end
            stk_pkg::ST_FETCH:
            begin
                if (cmd_reg == stk_pkg::CMD_READ)
                begin
                    slot_raddr = rslot;
                    if (!phase_reg)
                    begin
                        ent_next   = slot_rd_reg;
                        idx_next   = '0;
                        state_next = stk_pkg::ST_PRES;
                        // A rank beyond the last entry reads as an empty entry.
                        if (32'(rnk_reg) >= ENTRIES)
                        begin
                            ent_next = '0;
                        end
                    end
                    phase_next = 1'b0;
                end
                else
                begin
                    // slot data of rank idx is arriving now
                    if ((cmd_reg == stk_pkg::CMD_INSERT && score_reg > slot_rd_reg[63:32])
                        || (cmd_reg == stk_pkg::CMD_DELETE && slot_rd_reg[31:0] == key_reg))
                    begin
                        hitv_next   = 1'b1;
                        hit_next    = idx_reg;
                        victim_next = carry_reg;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    state_next = stk_pkg::ST_SCAN;
                end
            end
            stk_pkg::ST_SHIFT:
            begin
                // Insert: read rank[idx-1], write it to rank[idx], going down to hit.
                // Delete: read rank[idx+1], write to rank[idx], going up to LAST.
                if (!phase_reg)
                begin
                    if (cmd_reg == stk_pkg::CMD_INSERT)
                    begin
                        if (idx_reg == LAST && !pv_reg)
                        begin
                            rank_raddr = idx_a;
                            rd_en      = 1'b1;
                            phase_next = 1'b0;
                            state_next = stk_pkg::ST_SHIFT;
                            carry_next = '0;
                        end
                        if (pv_reg && pidx_reg == LAST && idx_reg == LAST)
                        begin
                            victim_next = rank_rd_reg;
                        end
                        if (idx_reg == hit_reg && (pv_reg || idx_reg != LAST))
                        begin
                            state_next = stk_pkg::ST_FINISH;
                        end
                        else if (pv_reg || idx_reg != LAST)
                        begin
                            rank_raddr = AW'(idx_reg - 1'b1);
                            phase_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (idx_reg == LAST)
                        begin
                            state_next = stk_pkg::ST_FINISH;
                        end
                        else
                        begin
                            rank_raddr = AW'(idx_reg + 1'b1);
                            phase_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    rank_we    = 1'b1;
                    rank_waddr = idx_a;
                    rank_wdata = rank_rd_reg;
                    phase_next = 1'b0;
                    idx_next   = (cmd_reg == stk_pkg::CMD_INSERT) ? idx_reg - 1'b1
                                                                  : idx_reg + 1'b1;
                end
            end
            stk_pkg::ST_FINISH:
            begin
                rank_we    = 1'b1;
                rank_waddr = idx_a;
                rank_wdata = victim_reg;
                slot_we    = 1'b1;
                slot_waddr = victim_reg;
                slot_wdata = (cmd_reg == stk_pkg::CMD_INSERT)
                             ? {pay_reg, score_reg, key_reg} : '0;
                idx_next   = '0;
                state_next = stk_pkg::ST_PRES;
            end
            stk_pkg::ST_PRES:
            begin
                // slot-order presence scan, then last-rank score
                rd_en = 1'b1;
                if (pv_reg && !phase_reg && slot_rd_reg[31:0] == key_reg
                    && slot_rd_reg[63:32] != 32'd0)
                begin
                    present_next = 1'b1;
                end
                if (!phase_reg)
                begin
                    if (idx_reg == CNT)
                    begin
                        rank_raddr = LAST[AW-1:0];
                        rd_en      = 1'b0;
                        phase_next = 1'b1;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (idx_reg == '0)
                begin
                    slot_raddr = rslot;
                    idx_next   = CW'(1);
                end
                else
                begin
                    min_next   = slot_rd_reg[63:32];
                    state_next = stk_pkg::ST_OUT;
                end
            end
            stk_pkg::ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = stk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stk_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = (state_reg == stk_pkg::ST_OUT);
    assign m_axis_tdata  = {{(stk_pkg::OUT_BYTES*8-stk_pkg::OUT_BITS){1'b0}},
                            min_reg, ent_reg[127:64], ent_reg[63:32], ent_reg[31:0],
                            present_reg, found_reg, status_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg     <= 1'b0;
            init_cnt_reg <= '0;
            state_reg    <= stk_pkg::ST_IDLE;
            pv_reg       <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            if (!init_reg)
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
                if (init_cnt_reg == LAST)
                begin
                    init_reg <= 1'b1;
                end
            end
            state_reg <= state_next;
            pv_reg    <= rd_en;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_axis_tdata[2:0];
            key_reg   <= s_axis_tdata[34:3];
            score_reg <= s_axis_tdata[66:35];
            pay_reg   <= s_axis_tdata[130:67];
            rnk_reg   <= s_axis_tdata[134:131];
        end
        pidx_reg    <= idx_reg;
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        hitv_reg    <= hitv_next;
        carry_reg   <= carry_next;
        victim_reg  <= victim_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        present_reg <= present_next;
        ent_reg     <= ent_next;
        min_reg     <= min_next;
    end

`ifndef SYNTHESIS
    ap_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != stk_pkg::ST_IDLE) |-> !s_axis_tready)
        else $error("input ready while busy");
    ap_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped under stall");
    ap_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stk_pkg::ST_IDLE && init_reg) |-> !slot_we)
        else $error("slot write while idle");
`endif

endmodule
`default_nettype wire

[sim/sorted_top_k_score_buffer_top_tb.sv]
// Testbench for the sorted top-k score buffer: streamed commands checked against a predictor.
`default_nettype none
module sorted_top_k_score_buffer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ENTRIES = 16;
    localparam int unsigned RANDOM_ITEMS = 1200;
    // Run limit that covers the slowest beats plus idle gaps and output stalls.
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam logic [2:0] CMD_BAD_LO = 3'd5;

    // One command beat as the block sees it.
    typedef struct packed {
        logic [3:0]  rank;
        logic [63:0] payload;
        logic [31:0] score;
        logic [31:0] id;
        logic [2:0]  cmd;
    } command_t;

    // One result beat, fields from the highest bit down.
    typedef struct packed {
        logic [31:0] min_score;
        logic [63:0] out_payload;
        logic [31:0] out_score;
        logic [31:0] out_id;
        logic        present;
        logic        found;
        logic        status;
    } answer_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [stk_pkg::IN_BYTES*8-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [stk_pkg::OUT_BYTES*8-1:0] m_axis_tdata;

    sorted_top_k_score_buffer_top #(.ENTRIES(ENTRIES)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Predictor state: rank list and slot contents.
    logic [3:0]  pr_rank[ENTRIES];
    logic [31:0] pr_id[ENTRIES];
    logic [31:0] pr_score[ENTRIES];
    logic [63:0] pr_payload[ENTRIES];

    command_t pending_cmds[$];
    answer_t  expected_answers[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit stimulus_done = 1'b0;
    bit quiet_sender;
    bit quiet_receiver;
    logic s_axis_tready_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one command to the predictor and returns the answer it produces.
    function automatic answer_t predict_answer(command_t c);
        answer_t a;
        int r;
        int j;
        logic [3:0] victim;
        a = '0;
        case (c.cmd)
            stk_pkg::CMD_CLEAR:
            begin
                for (j = 0; j < ENTRIES; j++)
                begin
                    pr_id[j] = '0;
                    pr_score[j] = '0;
                    pr_payload[j] = '0;
                end
            end
            stk_pkg::CMD_INSERT:
            begin
                a.status = 1'b1;
                for (r = 0; r < ENTRIES; r++)
                begin
                    if (c.score > pr_score[pr_rank[r]])
                    begin
                        victim = pr_rank[ENTRIES-1];
                        for (j = ENTRIES - 1; j > r; j--)
                            pr_rank[j] = pr_rank[j-1];
                        pr_rank[r] = victim;
                        pr_id[victim] = c.id;
                        pr_score[victim] = c.score;
                        pr_payload[victim] = c.payload;
                        a.status = 1'b0;
                        break;
                    end
                end
            end
            stk_pkg::CMD_DELETE:
            begin
                for (r = 0; r < ENTRIES; r++)
                begin
                    victim = pr_rank[r];
                    if (pr_id[victim] == c.id)
                    begin
                        pr_id[victim] = '0;
                        pr_score[victim] = '0;
                        pr_payload[victim] = '0;
                        for (j = r; j + 1 < ENTRIES; j++)
                            pr_rank[j] = pr_rank[j+1];
                        pr_rank[ENTRIES-1] = victim;
                        break;
                    end
                end
            end
            stk_pkg::CMD_READ:
            begin
                // Ranks are four bits wide, so every rank is in range here.
                victim = pr_rank[c.rank];
                a.out_id = pr_id[victim];
                a.out_score = pr_score[victim];
                a.out_payload = pr_payload[victim];
            end
            stk_pkg::CMD_LOOKUP:
            begin
                for (j = 0; j < ENTRIES; j++)
                begin
                    if (pr_id[j] == c.id)
                    begin
                        a.found = 1'b1;
                        a.out_id = pr_id[j];
                        a.out_score = pr_score[j];
                        a.out_payload = pr_payload[j];
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        // Presence and the minimum score are reported after every command.
        for (j = 0; j < ENTRIES; j++)
        begin
            if (pr_id[j] == c.id && pr_score[j] != 0)
            begin
                a.present = 1'b1;
                break;
            end
        end
        a.min_score = pr_score[pr_rank[ENTRIES-1]];
        return a;
    endfunction

    function automatic command_t make_command(logic [2:0] cmd, logic [31:0] id,
                                              logic [31:0] score, logic [63:0] payload,
                                              logic [3:0] rank);
        command_t c;
        c.cmd = cmd;
        c.id = id;
        c.score = score;
        c.payload = payload;
        c.rank = rank;
        return c;
    endfunction

    function automatic logic [63:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    // Ids come mostly from a small pool so deletes and lookups hit held entries.
    function automatic logic [31:0] pick_id();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return 32'($urandom_range(0, 11));
        else if (sel < 8)
            return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
        return $urandom;
    endfunction

    // Scores lean on a narrow range so ties and rejected inserts happen often.
    function automatic logic [31:0] pick_score();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return 32'($urandom_range(0, 40)) << 16;
        else if (sel < 6)
            return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        return $urandom;
    endfunction

    // Directed opening, then a random mix weighted toward insert and delete.
    initial
    begin
        int n;
        int unsigned sel;
        logic [2:0] cmd;
        pending_cmds.push_back(make_command(stk_pkg::CMD_READ, 32'd0, 32'd0, 64'd0, 4'd0));
        pending_cmds.push_back(make_command(stk_pkg::CMD_LOOKUP, 32'd0, 32'd0, 64'd0, 4'd15));
        // Inserting a zero score into an empty buffer is rejected.
        pending_cmds.push_back(make_command(stk_pkg::CMD_INSERT, 32'd7, 32'd0, 64'd1, 4'd0));
        pending_cmds.push_back(make_command(stk_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                            64'hFFFF_FFFF_FFFF_FFFF, 4'd0));
        pending_cmds.push_back(make_command(stk_pkg::CMD_INSERT, 32'd1, 32'd1, 64'd0, 4'd0));
        // A tie does not displace the held score; it lands below it.
        pending_cmds.push_back(make_command(stk_pkg::CMD_INSERT, 32'd2, 32'd1, 64'hA5A5,
                                            4'd0));
        pending_cmds.push_back(make_command(stk_pkg::CMD_READ, 32'd0, 32'd0, 64'd0, 4'd2));
        pending_cmds.push_back(make_command(stk_pkg::CMD_READ, 32'd0, 32'd0, 64'd0, 4'd15));
        pending_cmds.push_back(make_command(stk_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0, 64'd0,
                                            4'd0));
        pending_cmds.push_back(make_command(stk_pkg::CMD_LOOKUP, 32'h1234_5678, 32'd0, 64'd0,
                                            4'd0));
        // Delete of an id that is not held, then of id zero.
        pending_cmds.push_back(make_command(stk_pkg::CMD_DELETE, 32'h1234_5678, 32'd0, 64'd0,
                                            4'd0));
        pending_cmds.push_back(make_command(stk_pkg::CMD_DELETE, 32'd0, 32'd0, 64'd0, 4'd0));
        pending_cmds.push_back(make_command(stk_pkg::CMD_DELETE, 32'd1, 32'd0, 64'd0, 4'd0));
        for (n = 0; n < 16; n++)
            pending_cmds.push_back(make_command(stk_pkg::CMD_INSERT, 32'(n + 100),
                                                32'(n + 5) << 16, rand_payload(), 4'd0));
        // A full buffer rejects a score no higher than its minimum.
        pending_cmds.push_back(make_command(stk_pkg::CMD_INSERT, 32'd9, 32'd5 << 16, 64'd3,
                                            4'd0));
        pending_cmds.push_back(make_command(stk_pkg::CMD_READ, 32'd0, 32'd0, 64'd0, 4'd15));
        for (n = 5; n <= 7; n++)
            pending_cmds.push_back(make_command(3'(n), 32'd105, $urandom, rand_payload(),
                                                4'($urandom)));
        pending_cmds.push_back(make_command(stk_pkg::CMD_CLEAR, 32'd105, 32'd0, 64'd0, 4'd0));
        pending_cmds.push_back(make_command(stk_pkg::CMD_LOOKUP, 32'd0, 32'd0, 64'd0, 4'd0));

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                cmd = stk_pkg::CMD_INSERT;
            else if (sel < 60)
                cmd = stk_pkg::CMD_DELETE;
            else if (sel < 75)
                cmd = stk_pkg::CMD_READ;
            else if (sel < 92)
                cmd = stk_pkg::CMD_LOOKUP;
            else if (sel < 95)
                cmd = stk_pkg::CMD_CLEAR;
            else
                cmd = 3'($urandom_range(CMD_BAD_LO, 7));
            pending_cmds.push_back(make_command(cmd, pick_id(), pick_score(), rand_payload(),
                                                4'($urandom)));
        end
        stimulus_done = 1'b1;
    end

    // Reset and predictor initialization.
    initial
    begin
        int j;
        rst_n = 1'b0;
        for (j = 0; j < ENTRIES; j++)
        begin
            pr_rank[j] = 4'(j);
            pr_id[j] = '0;
            pr_score[j] = '0;
            pr_payload[j] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Quiet windows: for a stretch in the middle of the run neither side idles.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        quiet_sender <= (cycles > 6000 && cycles < 14000);
        quiet_receiver <= (cycles > 6000 && cycles < 14000);
    end

    // Driver: changes inputs at the falling edge, holding a beat until it is taken.
    always @(negedge clk)
    begin
        command_t c;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready_seen)
        begin
            if (pending_cmds.size() != 0 && (quiet_sender || $urandom_range(0, 99) >= 34))
            begin
                c = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= (stk_pkg::IN_BYTES*8)'(c);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Acceptance is sampled at the rising edge; the predictor runs on each accepted beat.
    always @(posedge clk)
    begin
        s_axis_tready_seen <= 1'b0;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            s_axis_tready_seen <= 1'b1;
            expected_answers.push_back(predict_answer(command_t'(s_axis_tdata[$bits(command_t)-1:0])));
        end
    end

    // Receiver stall pattern, driven at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= quiet_receiver || ($urandom_range(0, 99) >= 34);
    end

    // Monitor: compares each result beat with the oldest expected answer.
    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = answer_t'(m_axis_tdata[$bits(answer_t)-1:0]);
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.found !== want.found)
                begin
                    $display("%0t: found expected %0d got %0d", $time, want.found, got.found);
                    errors++;
                end
                if (got.present !== want.present)
                begin
                    $display("%0t: present expected %0d got %0d", $time, want.present,
                             got.present);
                    errors++;
                end
                if (got.out_id !== want.out_id)
                begin
                    $display("%0t: out_id expected %h got %h", $time, want.out_id, got.out_id);
                    errors++;
                end
                if (got.out_score !== want.out_score)
                begin
                    $display("%0t: out_score expected %h got %h", $time, want.out_score,
                             got.out_score);
                    errors++;
                end
                if (got.out_payload !== want.out_payload)
                begin
                    $display("%0t: out_payload expected %h got %h", $time, want.out_payload,
                             got.out_payload);
                    errors++;
                end
                if (got.min_score !== want.min_score)
                begin
                    $display("%0t: min_score expected %h got %h", $time, want.min_score,
                             got.min_score);
                    errors++;
                end
            end
        end
    end

    // End of run: drain, allow a further latency window, then report.
    initial
    begin
        wait (stimulus_done);
        while ((pending_cmds.size() != 0 || s_axis_tvalid || expected_answers.size() != 0)
               && cycles < CYCLE_LIMIT)
            @(posedge clk);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            repeat (4 * ENTRIES + 20) @(posedge clk);
            if (errors == 0)
                $display("PASS");
            else
                $display("FAIL");
            $finish;
        end
    end

endmodule
`default_nettype wire
